@@ rtl/lif_neuron_population_update_macros.svh @@
// assertion macros shared by the checker of the neuron population update block
`ifndef LIF_NEURON_POPULATION_UPDATE_MACROS_SVH
`define LIF_NEURON_POPULATION_UPDATE_MACROS_SVH

// same-cycle implication, ignored while in reset
`define LNPU_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, ignored while in reset
`define LNPU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also holds through reset
`define LNPU_ASSERT_NEXT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/lnpu_pkg.sv @@
// shared types and constants of the neuron population update block
`default_nettype none

package lnpu_pkg;

  localparam int LEVEL_W = 24;
  localparam int LEAK_W  = 16;
  localparam int TICK_W  = 16;
  localparam int INDEX_W = 10;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_THRESHOLD  = 3'd0,
    REG_RESET      = 3'd1,
    REG_REST       = 3'd2,
    REG_LEAK       = 3'd3,
    REG_REFRACTORY = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic signed [LEVEL_W-1:0] threshold_level;
    logic signed [LEVEL_W-1:0] reset_level;
    logic signed [LEVEL_W-1:0] rest_level;
    logic        [LEAK_W-1:0]  leak_factor;
    logic        [TICK_W-1:0]  refractory_ticks;
  } cfg_t;

  // one neuron's stored state
  typedef struct packed {
    logic                      spike_pending;
    logic        [TICK_W-1:0]  refractory;
    logic signed [LEVEL_W-1:0] membrane;
  } state_t;

  localparam logic signed [LEVEL_W-1:0] THRESHOLD_DEFAULT = -24'sd3604480;
  localparam logic signed [LEVEL_W-1:0] RESET_DEFAULT     = -24'sd5242880;
  localparam logic signed [LEVEL_W-1:0] REST_DEFAULT      = -24'sd4587520;
  localparam logic        [LEAK_W-1:0]  LEAK_DEFAULT      = 16'd66;
  localparam logic        [TICK_W-1:0]  TICKS_DEFAULT     = 16'd200;

  localparam cfg_t CFG_DEFAULT = '{
    threshold_level:  THRESHOLD_DEFAULT,
    reset_level:      RESET_DEFAULT,
    rest_level:       REST_DEFAULT,
    leak_factor:      LEAK_DEFAULT,
    refractory_ticks: TICKS_DEFAULT
  };

  // state of every neuron after the clearing pass
  localparam state_t STATE_RESET = '{
    spike_pending: 1'b0,
    refractory:    16'd0,
    membrane:      -24'sd5242880
  };

endpackage

`default_nettype wire

@@ rtl/lnpu_state_mem.sv @@
// per-neuron state memory with one write port, one registered read port and a clearing pass
`default_nettype none

module lnpu_state_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   rd_en,
  input  wire logic [AW-1:0]          rd_addr,
  output lnpu_pkg::state_t            rd_data,
  input  wire logic                   wr_en,
  input  wire logic [AW-1:0]          wr_addr,
  input  wire lnpu_pkg::state_t       wr_data,
  output logic                        busy
);

  lnpu_pkg::state_t mem [DEPTH];
  lnpu_pkg::state_t rd_data_r;
  logic             clearing_r;
  logic [AW-1:0]    clr_addr_r;

  // clearing pass walks every entry once after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      if (clr_addr_r == AW'(DEPTH - 1)) begin
        clearing_r <= 1'b0;
      end
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing_r) begin
      mem[clr_addr_r] <= lnpu_pkg::STATE_RESET;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
  assign busy    = clearing_r;

endmodule

`default_nettype wire

@@ rtl/lnpu_update.sv @@
// one leaky integrate-and-fire time step for a single neuron
`default_nettype none

module lnpu_update (
  input  wire lnpu_pkg::cfg_t              cfg,
  input  wire lnpu_pkg::state_t            cur,
  input  wire logic signed [23:0]          input_sum,
  output lnpu_pkg::state_t                 nxt,
  output logic                             fired
);

  function automatic logic signed [23:0] sat24(input logic signed [26:0] v);
    logic signed [23:0] r;
    if (v > 27'sd8388607) begin
      r = 24'sh7fffff;
    end else if (v < -27'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

  logic        [15:0] count;
  logic signed [26:0] sum_wide;
  logic signed [23:0] integ;
  logic signed [24:0] diff;
  logic signed [41:0] prod;
  logic signed [41:0] prod_rnd;
  logic signed [25:0] delta;
  logic signed [26:0] leak_wide;
  logic signed [23:0] leaked;

  always_comb begin
    // a spike from the previous step loads the refractory count
    count     = cur.spike_pending ? cfg.refractory_ticks : cur.refractory;
    sum_wide  = 27'(cur.membrane) + 27'(input_sum);
    integ     = sat24(sum_wide);
    diff      = 25'(cfg.rest_level) - 25'(integ);
    prod      = 42'(diff) * 42'($signed({1'b0, cfg.leak_factor}));
    // round half up, then floor by taking the upper bits
    prod_rnd  = prod + 42'sd32768;
    delta     = prod_rnd[41:16];
    leak_wide = 27'(integ) + 27'(delta);
    leaked    = sat24(leak_wide);

    nxt.spike_pending = 1'b0;
    nxt.refractory    = count;
    nxt.membrane      = leaked;
    fired             = 1'b0;
    if (count != 16'd0) begin
      nxt.refractory = count - 16'd1;
      nxt.membrane   = cfg.reset_level;
    end else if (integ > cfg.threshold_level) begin
      nxt.spike_pending = 1'b1;
      nxt.membrane      = cfg.reset_level;
      fired             = 1'b1;
    end
  end

endmodule

`default_nettype wire

@@ rtl/lif_neuron_population_update.sv @@
// top level of the time-multiplexed leaky integrate-and-fire neuron population
//
// each request on the in_ stream advances one neuron by one time step and gives exactly one
// result on the out_ stream, in request order. the block takes one request per clock while
// the result register is free or being drained and no clearing pass runs; a request is
// registered with its state memory read, then its update goes into the result register.
// the rate is set by the per-neuron state memory, which has one read and one write port: it
// is read on the accept edge and written back when the request moves into the result
// register; a one-entry bypass covers back-to-back requests to the same neuron. after reset
// a clearing pass writes every state entry, one per cycle, min(NEURON_COUNT, 1024) entries
// in all, with in_tready low; configuration writes are taken meanwhile. an index at or above
// NEURON_COUNT leaves all state untouched and returns fired = 0 and a membrane level of 0.
// configuration is written only while the block is idle: a rule on the user, not enforced.
`default_nettype none

module lif_neuron_population_update #(
  parameter int NEURON_COUNT = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // request stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // neuron_index[9:0], input_sum[33:10], zero[39:34]
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // neuron_id[9:0], membrane_level[33:10], zero[39:34]
  output logic             out_tuser,  // fired[0]
  // configuration writes
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [23:0] cfg_wdata
);

  // only indexes that the 10-bit field can reach get storage
  localparam int DEPTH = (NEURON_COUNT < 1024) ? NEURON_COUNT : 1024;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // configuration registers
  lnpu_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= lnpu_pkg::CFG_DEFAULT;
    end else if (cfg_we) begin
      case (lnpu_pkg::cfg_reg_t'(cfg_index))
        lnpu_pkg::REG_THRESHOLD:  cfg_r.threshold_level  <= cfg_wdata;
        lnpu_pkg::REG_RESET:      cfg_r.reset_level      <= cfg_wdata;
        lnpu_pkg::REG_REST:       cfg_r.rest_level       <= cfg_wdata;
        lnpu_pkg::REG_LEAK:       cfg_r.leak_factor      <= cfg_wdata[15:0];
        lnpu_pkg::REG_REFRACTORY: cfg_r.refractory_ticks <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // handshake: the pipeline moves whenever the result register is free or being drained
  logic advance;
  logic accept;
  logic mem_busy;
  logic out_valid_r;

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = advance && !mem_busy;
  assign accept    = in_tvalid && in_tready;

  // update stage, loaded on accept while the state memory is read
  logic               s1_valid_r;
  logic [9:0]         s1_idx_r;
  logic signed [23:0] s1_input_r;
  logic               s1_in_range;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_idx_r   <= in_tdata[9:0];
      s1_input_r <= in_tdata[33:10];
    end
  end

  assign s1_in_range = 17'(s1_idx_r) < 17'(NEURON_COUNT);

  // state memory
  lnpu_pkg::state_t mem_rd_data;
  lnpu_pkg::state_t cur_state;
  lnpu_pkg::state_t nxt_state;
  logic             wr_en;
  logic             fired;

  assign wr_en = s1_valid_r && advance && s1_in_range;

  lnpu_state_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_state_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (in_tdata[AW-1:0]),
    .rd_data (mem_rd_data),
    .wr_en   (wr_en),
    .wr_addr (s1_idx_r[AW-1:0]),
    .wr_data (nxt_state),
    .busy    (mem_busy)
  );

  // bypass of the latest write back: covers a read that met a write to the same neuron
  logic             byp_valid_r;
  logic [9:0]       byp_idx_r;
  lnpu_pkg::state_t byp_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_valid_r <= 1'b0;
    end else if (wr_en) begin
      byp_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      byp_idx_r  <= s1_idx_r;
      byp_data_r <= nxt_state;
    end
  end

  assign cur_state = (byp_valid_r && byp_idx_r == s1_idx_r) ? byp_data_r : mem_rd_data;

  lnpu_update u_update (
    .cfg       (cfg_r),
    .cur       (cur_state),
    .input_sum (s1_input_r),
    .nxt       (nxt_state),
    .fired     (fired)
  );

  // result register
  logic [9:0]         out_id_r;
  logic               out_fired_r;
  logic signed [23:0] out_level_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      out_id_r    <= s1_idx_r;
      // out-of-population requests report zeros
      out_fired_r <= s1_in_range ? fired : 1'b0;
      out_level_r <= s1_in_range ? nxt_state.membrane : 24'sd0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_level_r, out_id_r};
  assign out_tuser  = out_fired_r;

endmodule

`default_nettype wire

@@ rtl/lnpu_checker.sv @@
// port-level checker of the neuron population update block and its bind
`default_nettype none

`include "lif_neuron_population_update_macros.svh"

module lnpu_checker #(
  parameter int NEURON_COUNT = 1024
) (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [39:0] out_tdata,
  input wire logic        out_tuser,
  input wire logic        cfg_we
);

  logic out_of_range;

  assign out_of_range = 17'(out_tdata[9:0]) >= 17'(NEURON_COUNT);

  // a stalled result holds
  `LNPU_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result changed while stalled")

  // requests outside the population report no spike and a zero level
  `LNPU_ASSERT_SAME(a_out_of_range, out_tvalid && out_of_range, !out_tuser && out_tdata[33:10] == 24'd0, "out-of-population result not zero")

  // the clearing pass keeps requests out right after reset
  `LNPU_ASSERT_NEXT_ALWAYS(a_clear_after_reset, !rst_n, !in_tready && !out_tvalid, "block ready during clearing pass")

  // padding bits stay zero
  `LNPU_ASSERT_SAME(a_out_pad, out_tvalid, out_tdata[39:34] == 6'd0, "result padding not zero")

  // configuration is only written while no request or result is on the streams
  `LNPU_ASSERT_SAME(a_cfg_idle, cfg_we, !in_tvalid && !out_tvalid, "configuration written while busy")

endmodule

bind lif_neuron_population_update lnpu_checker #(
  .NEURON_COUNT (NEURON_COUNT)
) u_lnpu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .cfg_we     (cfg_we)
);

`default_nettype wire
